// File: rtl/calendar_day_number_converter_top_defines.svh
// Assertion macros shared by the calendar day-number converter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CALENDAR_DAY_NUMBER_CONVERTER_TOP_DEFINES_SVH
`define CALENDAR_DAY_NUMBER_CONVERTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CDN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CDN_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDN_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDN_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/cdn_pkg.sv
// Package for the calendar day-number converter: widths, codes, constants,
// reciprocal multipliers and the month offset table. No dependencies.
`default_nettype none

package cdn_pkg;

    // Pipeline: stages 0..5 do the math, the last stage is the output register
    localparam int NUM_STAGES = 7;
    localparam int OUT_STAGE  = NUM_STAGES - 1;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int JDN_W   = 23;
    localparam int SOD_W   = 17;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DATE  = 2'd1,
        ERR_TIME  = 2'd2,
        ERR_RANGE = 2'd3
    } t_err;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
        logic [NUM_STAGES-1:0] cmd;
    } t_pipe_ctl;

    localparam logic [JDN_W-1:0]  JDN_MIN     = 23'd1721060;
    localparam logic [JDN_W-1:0]  JDN_MAX     = 23'd5373484;
    localparam logic [SOD_W-1:0]  SEC_PER_DAY = 17'd86400;
    localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;

    localparam int YEAR_BIAS     = 4800;
    localparam int JDN_ENC_OFS   = 32045;
    localparam int JDN_DEC_OFS   = 32044;
    localparam int DAYS_PER_YEAR = 365;
    localparam int DAYS_PER_4Y   = 1461;
    localparam int DAYS_PER_400Y = 146097;
    localparam int MONTH_DIV     = 153;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_MIN   = 60;

    // floor(x / D) == (x * ceil(2^S / D)) >> S for x below 2^(S - ceil(log2 D))
    localparam int Q25_SHIFT = 15;
    localparam logic [63:0] Q25_MUL = ((64'd1 << Q25_SHIFT) + 64'd24) / 64'd25;
    localparam int Q25_W = $clog2(Q25_MUL + 64'd1);

    localparam int B_SHIFT = 43;
    localparam logic [63:0] B_MUL =
        ((64'd1 << B_SHIFT) + 64'(DAYS_PER_400Y) - 64'd1) / 64'(DAYS_PER_400Y);
    localparam int B_MUL_W = $clog2(B_MUL + 64'd1);

    localparam int D_SHIFT = 29;
    localparam logic [63:0] D_MUL =
        ((64'd1 << D_SHIFT) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y);
    localparam int D_MUL_W = $clog2(D_MUL + 64'd1);

    localparam int M_SHIFT = 19;
    localparam logic [63:0] M_MUL =
        ((64'd1 << M_SHIFT) + 64'(MONTH_DIV) - 64'd1) / 64'(MONTH_DIV);
    localparam int M_MUL_W = $clog2(M_MUL + 64'd1);

    localparam int H_SHIFT = 29;
    localparam logic [63:0] H_MUL =
        ((64'd1 << H_SHIFT) + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR);
    localparam int H_MUL_W = $clog2(H_MUL + 64'd1);

    localparam int MI_SHIFT = 18;
    localparam logic [63:0] MI_MUL =
        ((64'd1 << MI_SHIFT) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN);
    localparam int MI_MUL_W = $clog2(MI_MUL + 64'd1);

    // (153 * m + 2) / 5 for March-based month index m
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cdn_pipe_ctrl.sv
// Pipeline control: per-stage valid bits, load enables and command tags.
// Depends on cdn_pkg and the assertion macro header.
`default_nettype none
`include "calendar_day_number_converter_top_defines.svh"

module cdn_pipe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_cmd,
    output logic                   o_ready,
    input  wire logic              i_ready,
    output cdn_pkg::t_pipe_ctl     o_ctl
);
    import cdn_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] r_cmd;
    logic [NUM_STAGES-1:0] w_load;

    // A stage takes new data when empty or when its contents move on
    always_comb begin
        w_load[OUT_STAGE] = !r_valid[OUT_STAGE] || i_ready;
        for (int k = OUT_STAGE - 1; k >= 0; k--) begin
            w_load[k] = !r_valid[k] || w_load[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_load[0]) begin
            n_valid[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_load[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_cmd[0] <= i_cmd;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_load[k]) begin
                r_cmd[k] <= r_cmd[k-1];
            end
        end
    end

    assign o_ready     = w_load[0];
    assign o_ctl.load  = w_load;
    assign o_ctl.valid = r_valid;
    assign o_ctl.cmd   = r_cmd;

    `CDN_ASSERT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready |=> r_valid[0], "accepted transaction not in first stage")
    `CDN_ASSERT(a_stall_holds, i_clk, i_rst_n, r_valid[1] && !w_load[1] |=> r_valid[1], "stalled stage lost its transaction")
    `CDN_ASSERT(a_moves_to_out, i_clk, i_rst_n, r_valid[OUT_STAGE-1] && w_load[OUT_STAGE] |=> r_valid[OUT_STAGE], "transaction dropped before output")
    `CDN_ASSERT_NR(a_reset_empties, i_clk, !i_rst_n |=> !r_valid[OUT_STAGE], "output valid after reset")

endmodule

`default_nettype wire

// File: rtl/cdn_encode.sv
// Encode datapath: date/time checks and Julian day number, six stages.
// Depends on cdn_pkg.
`default_nettype none

module cdn_encode (
    input  wire logic                          i_clk,
    input  wire logic [cdn_pkg::NUM_STAGES-1:0] i_load,
    input  wire logic [cdn_pkg::YEAR_W-1:0]    i_year,
    input  wire logic [cdn_pkg::MONTH_W-1:0]   i_month,
    input  wire logic [cdn_pkg::DAY_W-1:0]     i_day,
    input  wire logic [cdn_pkg::HOUR_W-1:0]    i_hour,
    input  wire logic [cdn_pkg::MIN_W-1:0]     i_minute,
    input  wire logic [cdn_pkg::SEC_W-1:0]     i_second,
    output logic [cdn_pkg::JDN_W-1:0]          o_day_number,
    output logic [cdn_pkg::SOD_W-1:0]          o_seconds_of_day,
    output cdn_pkg::t_err                      o_err
);
    import cdn_pkg::*;

    localparam int Y4_W    = YEAR_W - 2;
    localparam int YP_W    = Y4_W + Q25_W;
    localparam int YQ_W    = YP_W - Q25_SHIFT;
    localparam int YY_W    = 15;
    localparam int Q4_W    = YY_W - 2;
    localparam int Q4P_W   = Q4_W + Q25_W;
    localparam int Q100_W  = Q4P_W - Q25_SHIFT;
    localparam int SUM_W   = 24;
    localparam int DPART_W = 10;

    // stage 0: field checks, March-based year and month, time of day
    logic              w_march;
    logic [YY_W-1:0]   w_yy;
    logic [3:0]        w_mm;
    logic              w_thirty;
    logic              w_base_bad;
    logic              w_feb29;
    logic              w_time_bad;
    logic [SOD_W-1:0]  w_sod;
    logic [Y4_W-1:0]   w_y4;

    always_comb begin
        w_march  = (i_month <= 4'd2);
        w_yy     = YY_W'(i_year) + YY_W'(YEAR_BIAS) - YY_W'(w_march);
        w_mm     = w_march ? (i_month + 4'd9) : (i_month - 4'd3);
        w_thirty = (i_month == 4'd4) || (i_month == 4'd6) || (i_month == 4'd9)
                || (i_month == 4'd11);
        w_base_bad = (i_year > YEAR_MAX) || (i_month == 4'd0) || (i_month > 4'd12)
                  || (i_day == 5'd0) || (w_thirty && (i_day > 5'd30))
                  || ((i_month == 4'd2) && (i_day > 5'd29));
        w_feb29    = (i_month == 4'd2) && (i_day == 5'd29);
        w_time_bad = (i_hour > 5'd23) || (i_minute > 6'd59) || (i_second > 6'd59);
        w_sod = SOD_W'(i_hour) * SOD_W'(SEC_PER_HOUR) + SOD_W'(i_minute) * SOD_W'(SEC_PER_MIN)
              + SOD_W'(i_second);
        w_y4  = i_year[YEAR_W-1:2];
    end

    logic [YY_W-1:0]  r0_yy;
    logic [3:0]       r0_mm;
    logic [DAY_W-1:0] r0_day;
    logic [1:0]       r0_y_lo;
    logic [Y4_W-1:0]  r0_y4;
    logic [YP_W-1:0]  r0_yprod;
    logic             r0_base_bad;
    logic             r0_feb29;
    logic             r0_time_bad;
    logic [SOD_W-1:0] r0_sod;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r0_yy       <= w_yy;
            r0_mm       <= w_mm;
            r0_day      <= i_day;
            r0_y_lo     <= i_year[1:0];
            r0_y4       <= w_y4;
            r0_yprod    <= YP_W'(w_y4) * YP_W'(Q25_MUL);
            r0_base_bad <= w_base_bad;
            r0_feb29    <= w_feb29;
            r0_time_bad <= w_time_bad;
            r0_sod      <= w_sod;
        end
    end

    // stage 1: leap year, error code, day-count products
    logic [YQ_W-1:0] w_yq;
    logic            w_y100;
    logic            w_y400;
    logic            w_leap;
    logic            w_date_bad;
    t_err            w_err;

    always_comb begin
        w_yq   = r0_yprod[Q25_SHIFT +: YQ_W];
        w_y100 = (r0_y_lo == 2'd0) && (r0_y4 == Y4_W'(Y4_W'(w_yq) * Y4_W'(25)));
        w_y400 = w_y100 && (w_yq[1:0] == 2'd0);
        w_leap = (r0_y_lo == 2'd0) && (!w_y100 || w_y400);
        w_date_bad = r0_base_bad || (r0_feb29 && !w_leap);
        priority if (w_date_bad) begin
            w_err = ERR_DATE;
        end else if (r0_time_bad) begin
            w_err = ERR_TIME;
        end else begin
            w_err = ERR_NONE;
        end
    end

    t_err               r1_err;
    logic [SOD_W-1:0]   r1_sod;
    logic [SUM_W-1:0]   r1_p365;
    logic [Q4_W-1:0]    r1_q4;
    logic [Q4P_W-1:0]   r1_q4prod;
    logic [DPART_W-1:0] r1_dpart;

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r1_err    <= w_err;
            r1_sod    <= r0_sod;
            r1_p365   <= SUM_W'(r0_yy) * SUM_W'(DAYS_PER_YEAR);
            r1_q4     <= r0_yy[YY_W-1:2];
            r1_q4prod <= Q4P_W'(r0_yy[YY_W-1:2]) * Q4P_W'(Q25_MUL);
            r1_dpart  <= DPART_W'(r0_day) + DPART_W'(month_offset(r0_mm));
        end
    end

    // stage 2: century corrections
    logic [Q100_W-1:0] w_q100;
    assign w_q100 = r1_q4prod[Q25_SHIFT +: Q100_W];

    t_err               r2_err;
    logic [SOD_W-1:0]   r2_sod;
    logic [SUM_W-1:0]   r2_sum;
    logic [DPART_W-1:0] r2_dpart;

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r2_err   <= r1_err;
            r2_sod   <= r1_sod;
            r2_sum   <= r1_p365 + SUM_W'(r1_q4) - SUM_W'(w_q100) + SUM_W'(w_q100 >> 2);
            r2_dpart <= r1_dpart;
        end
    end

    // stage 3: final day number, results cleared on error
    logic [SUM_W-1:0] w_jdn;
    assign w_jdn = r2_sum + SUM_W'(r2_dpart) - SUM_W'(JDN_ENC_OFS);

    t_err             r3_err;
    logic [JDN_W-1:0] r3_jdn;
    logic [SOD_W-1:0] r3_sod;

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r3_err <= r2_err;
            r3_jdn <= (r2_err == ERR_NONE) ? w_jdn[JDN_W-1:0] : '0;
            r3_sod <= (r2_err == ERR_NONE) ? r2_sod : '0;
        end
    end

    // stages 4 and 5: delay to match the decode path
    t_err             r4_err;
    logic [JDN_W-1:0] r4_jdn;
    logic [SOD_W-1:0] r4_sod;
    t_err             r5_err;
    logic [JDN_W-1:0] r5_jdn;
    logic [SOD_W-1:0] r5_sod;

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r4_err <= r3_err;
            r4_jdn <= r3_jdn;
            r4_sod <= r3_sod;
        end
        if (i_load[5]) begin
            r5_err <= r4_err;
            r5_jdn <= r4_jdn;
            r5_sod <= r4_sod;
        end
    end

    assign o_day_number     = r5_jdn;
    assign o_seconds_of_day = r5_sod;
    assign o_err            = r5_err;

endmodule

`default_nettype wire

// File: rtl/cdn_decode.sv
// Decode datapath: day number to Gregorian date, seconds to time, six stages.
// Depends on cdn_pkg.
`default_nettype none

module cdn_decode (
    input  wire logic                           i_clk,
    input  wire logic [cdn_pkg::NUM_STAGES-1:0] i_load,
    input  wire logic [cdn_pkg::JDN_W-1:0]      i_day_number,
    input  wire logic [cdn_pkg::SOD_W-1:0]      i_seconds_of_day,
    output logic [cdn_pkg::YEAR_W-1:0]          o_year,
    output logic [cdn_pkg::MONTH_W-1:0]         o_month,
    output logic [cdn_pkg::DAY_W-1:0]           o_day,
    output logic [cdn_pkg::HOUR_W-1:0]          o_hour,
    output logic [cdn_pkg::MIN_W-1:0]           o_minute,
    output logic [cdn_pkg::SEC_W-1:0]           o_second,
    output cdn_pkg::t_err                       o_err
);
    import cdn_pkg::*;

    localparam int A_W    = JDN_W + 1;
    localparam int XB_W   = A_W + 2;
    localparam int PB_W   = XB_W + B_MUL_W;
    localparam int B_W    = 8;
    localparam int PH_W   = SOD_W + H_MUL_W;
    localparam int BP_W   = 26;
    localparam int C_W    = 16;
    localparam int REM_W  = 12;
    localparam int XD_W   = C_W + 2;
    localparam int PD_W   = XD_W + D_MUL_W;
    localparam int D_W    = 7;
    localparam int PMI_W  = REM_W + MI_MUL_W;
    localparam int DP_W   = 18;
    localparam int E_W    = 9;
    localparam int XM_W   = 12;
    localparam int PM_W   = XM_W + M_MUL_W;
    localparam int YF_W   = 16;

    // stage 0: range check, shifted day count
    t_err             r0_err;
    logic [A_W-1:0]   r0_a;
    logic [SOD_W-1:0] r0_sec;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r0_err <= ((i_day_number < JDN_MIN) || (i_day_number > JDN_MAX)
                       || (i_seconds_of_day >= SEC_PER_DAY)) ? ERR_RANGE : ERR_NONE;
            r0_a   <= A_W'(i_day_number) + A_W'(JDN_DEC_OFS);
            r0_sec <= i_seconds_of_day;
        end
    end

    // stage 1: century index, hour
    logic [PB_W-1:0] w_pb;
    logic [PH_W-1:0] w_ph;
    assign w_pb = PB_W'({r0_a, 2'b11}) * PB_W'(B_MUL);
    assign w_ph = PH_W'(r0_sec) * PH_W'(H_MUL);

    t_err              r1_err;
    logic [A_W-1:0]    r1_a;
    logic [B_W-1:0]    r1_b;
    logic [SOD_W-1:0]  r1_sec;
    logic [HOUR_W-1:0] r1_h;

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r1_err <= r0_err;
            r1_a   <= r0_a;
            r1_b   <= w_pb[B_SHIFT +: B_W];
            r1_sec <= r0_sec;
            r1_h   <= w_ph[H_SHIFT +: HOUR_W];
        end
    end

    // stage 2: day within the century, seconds within the hour
    logic [BP_W-1:0]  w_bprod;
    logic [BP_W-1:0]  w_c;
    logic [SOD_W-1:0] w_rem;
    assign w_bprod = BP_W'(r1_b) * BP_W'(DAYS_PER_400Y);
    assign w_c     = BP_W'(r1_a) - (w_bprod >> 2);
    assign w_rem   = r1_sec - SOD_W'(r1_h) * SOD_W'(SEC_PER_HOUR);

    t_err              r2_err;
    logic [B_W-1:0]    r2_b;
    logic [C_W-1:0]    r2_c;
    logic [REM_W-1:0]  r2_rem;
    logic [HOUR_W-1:0] r2_h;

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r2_err <= r1_err;
            r2_b   <= r1_b;
            r2_c   <= w_c[C_W-1:0];
            r2_rem <= w_rem[REM_W-1:0];
            r2_h   <= r1_h;
        end
    end

    // stage 3: year within the century, minute
    logic [PD_W-1:0]  w_pd;
    logic [PMI_W-1:0] w_pmi;
    assign w_pd  = PD_W'({r2_c, 2'b11}) * PD_W'(D_MUL);
    assign w_pmi = PMI_W'(r2_rem) * PMI_W'(MI_MUL);

    t_err              r3_err;
    logic [B_W-1:0]    r3_b;
    logic [C_W-1:0]    r3_c;
    logic [D_W-1:0]    r3_d;
    logic [REM_W-1:0]  r3_rem;
    logic [HOUR_W-1:0] r3_h;
    logic [MIN_W-1:0]  r3_mi;

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r3_err <= r2_err;
            r3_b   <= r2_b;
            r3_c   <= r2_c;
            r3_d   <= w_pd[D_SHIFT +: D_W];
            r3_rem <= r2_rem;
            r3_h   <= r2_h;
            r3_mi  <= w_pmi[MI_SHIFT +: MIN_W];
        end
    end

    // stage 4: day of year from March, second
    logic [DP_W-1:0]  w_dprod;
    logic [C_W-1:0]   w_e;
    logic [REM_W-1:0] w_s;
    assign w_dprod = DP_W'(r3_d) * DP_W'(DAYS_PER_4Y);
    assign w_e     = r3_c - C_W'(w_dprod >> 2);
    assign w_s     = r3_rem - REM_W'(r3_mi) * REM_W'(SEC_PER_MIN);

    t_err              r4_err;
    logic [B_W-1:0]    r4_b;
    logic [D_W-1:0]    r4_d;
    logic [E_W-1:0]    r4_e;
    logic [HOUR_W-1:0] r4_h;
    logic [MIN_W-1:0]  r4_mi;
    logic [SEC_W-1:0]  r4_s;

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r4_err <= r3_err;
            r4_b   <= r3_b;
            r4_d   <= r3_d;
            r4_e   <= w_e[E_W-1:0];
            r4_h   <= r3_h;
            r4_mi  <= r3_mi;
            r4_s   <= w_s[SEC_W-1:0];
        end
    end

    // stage 5: March-based month index
    logic [XM_W-1:0] w_xm;
    logic [PM_W-1:0] w_pm;
    assign w_xm = XM_W'(r4_e) * XM_W'(5) + XM_W'(2);
    assign w_pm = PM_W'(w_xm) * PM_W'(M_MUL);

    t_err              r5_err;
    logic [B_W-1:0]    r5_b;
    logic [D_W-1:0]    r5_d;
    logic [E_W-1:0]    r5_e;
    logic [3:0]        r5_m;
    logic [HOUR_W-1:0] r5_h;
    logic [MIN_W-1:0]  r5_mi;
    logic [SEC_W-1:0]  r5_s;

    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            r5_err <= r4_err;
            r5_b   <= r4_b;
            r5_d   <= r4_d;
            r5_e   <= r4_e;
            r5_m   <= w_pm[M_SHIFT +: 4];
            r5_h   <= r4_h;
            r5_mi  <= r4_mi;
            r5_s   <= r4_s;
        end
    end

    // month index 10 and 11 are January and February of the next year
    logic            w_next_year;
    logic [YF_W-1:0] w_year;
    logic [E_W-1:0]  w_day;

    always_comb begin
        w_next_year = (r5_m >= 4'd10);
        w_year = YF_W'(r5_b) * YF_W'(100) + YF_W'(r5_d) + YF_W'(w_next_year)
               - YF_W'(YEAR_BIAS);
        w_day  = r5_e - month_offset(r5_m) + 9'd1;
    end

    assign o_year   = w_year[YEAR_W-1:0];
    assign o_month  = w_next_year ? (r5_m - 4'd9) : (r5_m + 4'd3);
    assign o_day    = w_day[DAY_W-1:0];
    assign o_hour   = r5_h;
    assign o_minute = r5_mi;
    assign o_second = r5_s;
    assign o_err    = r5_err;

endmodule

`default_nettype wire

// File: rtl/calendar_day_number_converter_top.sv
// Top level of the calendar day-number converter: pipeline control, encode
// and decode datapaths, output register. Depends on cdn_pkg, cdn_pipe_ctrl,
// cdn_encode, cdn_decode and the assertion macro header.
`default_nettype none
`include "calendar_day_number_converter_top_defines.svh"

// Converts Gregorian date and time to Julian day number and seconds of day
// (command 0) or back (command 1). Fully pipelined: a new transaction can be
// accepted every cycle unless a stall on the output has filled the stages.
// A result passes through seven register stages, six math stages
// (reciprocal multiplies on the decode side) plus the output register,
// the first of them loaded at acceptance.
// Stalls on the output back up stage by stage, so empty stages still accept.
// error_code: 0 ok, 1 bad date, 2 bad time, 3 decode input out of range; on
// any error all other result fields are zero, as are the fields that belong
// to the other command.
module calendar_day_number_converter_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_command,
    input  wire logic [cdn_pkg::YEAR_W-1:0]   i_in_year,
    input  wire logic [cdn_pkg::MONTH_W-1:0]  i_in_month,
    input  wire logic [cdn_pkg::DAY_W-1:0]    i_in_day,
    input  wire logic [cdn_pkg::HOUR_W-1:0]   i_in_hour,
    input  wire logic [cdn_pkg::MIN_W-1:0]    i_in_minute,
    input  wire logic [cdn_pkg::SEC_W-1:0]    i_in_second,
    input  wire logic [cdn_pkg::JDN_W-1:0]    i_in_day_number,
    input  wire logic [cdn_pkg::SOD_W-1:0]    i_in_seconds_of_day,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [cdn_pkg::JDN_W-1:0]         o_out_day_number,
    output logic [cdn_pkg::SOD_W-1:0]         o_out_seconds_of_day,
    output logic [cdn_pkg::YEAR_W-1:0]        o_out_year,
    output logic [cdn_pkg::MONTH_W-1:0]       o_out_month,
    output logic [cdn_pkg::DAY_W-1:0]         o_out_day,
    output logic [cdn_pkg::HOUR_W-1:0]        o_out_hour,
    output logic [cdn_pkg::MIN_W-1:0]         o_out_minute,
    output logic [cdn_pkg::SEC_W-1:0]         o_out_second,
    output logic [1:0]                        o_error_code
);
    import cdn_pkg::*;

    t_pipe_ctl w_ctl;

    cdn_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_command),
        .o_ready (o_ready),
        .i_ready (i_ready),
        .o_ctl   (w_ctl)
    );

    logic [JDN_W-1:0] w_enc_jdn;
    logic [SOD_W-1:0] w_enc_sod;
    t_err             w_enc_err;

    cdn_encode u_encode (
        .i_clk            (i_clk),
        .i_load           (w_ctl.load),
        .i_year           (i_in_year),
        .i_month          (i_in_month),
        .i_day            (i_in_day),
        .i_hour           (i_in_hour),
        .i_minute         (i_in_minute),
        .i_second         (i_in_second),
        .o_day_number     (w_enc_jdn),
        .o_seconds_of_day (w_enc_sod),
        .o_err            (w_enc_err)
    );

    logic [YEAR_W-1:0]  w_dec_year;
    logic [MONTH_W-1:0] w_dec_month;
    logic [DAY_W-1:0]   w_dec_day;
    logic [HOUR_W-1:0]  w_dec_hour;
    logic [MIN_W-1:0]   w_dec_minute;
    logic [SEC_W-1:0]   w_dec_second;
    t_err               w_dec_err;

    cdn_decode u_decode (
        .i_clk            (i_clk),
        .i_load           (w_ctl.load),
        .i_day_number     (i_in_day_number),
        .i_seconds_of_day (i_in_seconds_of_day),
        .o_year           (w_dec_year),
        .o_month          (w_dec_month),
        .o_day            (w_dec_day),
        .o_hour           (w_dec_hour),
        .o_minute         (w_dec_minute),
        .o_second         (w_dec_second),
        .o_err            (w_dec_err)
    );

    logic               w_dec_sel;
    logic               w_dec_ok;
    logic [JDN_W-1:0]   r_jdn;
    logic [SOD_W-1:0]   r_sod;
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;
    logic [HOUR_W-1:0]  r_hour;
    logic [MIN_W-1:0]   r_minute;
    logic [SEC_W-1:0]   r_second;
    t_err               r_err;

    assign w_dec_sel = (w_ctl.cmd[OUT_STAGE-1] == CMD_DECODE);
    assign w_dec_ok  = w_dec_sel && (w_dec_err == ERR_NONE);

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[OUT_STAGE]) begin
            r_jdn    <= w_dec_sel ? '0 : w_enc_jdn;
            r_sod    <= w_dec_sel ? '0 : w_enc_sod;
            r_year   <= w_dec_ok ? w_dec_year : '0;
            r_month  <= w_dec_ok ? w_dec_month : '0;
            r_day    <= w_dec_ok ? w_dec_day : '0;
            r_hour   <= w_dec_ok ? w_dec_hour : '0;
            r_minute <= w_dec_ok ? w_dec_minute : '0;
            r_second <= w_dec_ok ? w_dec_second : '0;
            r_err    <= w_dec_sel ? w_dec_err : w_enc_err;
        end
    end

    assign o_valid              = w_ctl.valid[OUT_STAGE];
    assign o_out_day_number     = r_jdn;
    assign o_out_seconds_of_day = r_sod;
    assign o_out_year           = r_year;
    assign o_out_month          = r_month;
    assign o_out_day            = r_day;
    assign o_out_hour           = r_hour;
    assign o_out_minute         = r_minute;
    assign o_out_second         = r_second;
    assign o_error_code         = r_err;

    `CDN_ASSERT(a_err_clears, i_clk, i_rst_n, o_valid && (o_error_code != ERR_NONE) |-> (o_out_day_number == '0) && (o_out_year == '0) && (o_out_month == '0), "error result carries data")
    `CDN_ASSERT(a_decode_no_jdn, i_clk, i_rst_n, o_valid && (o_out_month != '0) |-> (o_out_day_number == '0) && (o_out_seconds_of_day == '0), "decode result carries encode fields")
    `CDN_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_error_code) && $stable(o_out_day_number), "stalled result changed")

endmodule

`default_nettype wire
